// File: rtl/pwgc_pkg.sv
// Shared types, codes and helpers for the proximity wave gesture classifier.
// No dependencies.
package pwgc_pkg;

  localparam int DIST_W  = 16;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 8;
  localparam int GEST_W  = 3;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  // gesture codes
  localparam logic [GEST_W-1:0] G_NONE        = 3'd0;
  localparam logic [GEST_W-1:0] G_WAVE        = 3'd1;
  localparam logic [GEST_W-1:0] G_HOLDING     = 3'd2;
  localparam logic [GEST_W-1:0] G_HOLD        = 3'd3;
  localparam logic [GEST_W-1:0] G_NEAR_TO_FAR = 3'd4;
  localparam logic [GEST_W-1:0] G_FAR_TO_NEAR = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_WIN_MS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_STEP_MS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_MS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TOLERANCE = 3'd6;

  localparam logic [CFG_W-1:0] RELEASE_MS_RESET = 16'd500;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [TIME_W-1:0] time_ms;
  } in_beat_t;

  typedef struct packed {
    logic [GEST_W-1:0] gesture;
    logic [CNT_W-1:0]  count;
    logic [DIST_W-1:0] from_distance;
    logic [DIST_W-1:0] to_distance;
    logic              event_res;
  } out_beat_t;

  // signed wrapping difference now - then exceeds limit; negative never does
  function automatic logic elapsed_over(input logic [TIME_W-1:0] now,
                                        input logic [TIME_W-1:0] then_t,
                                        input logic [CFG_W-1:0]  limit);
    logic [TIME_W-1:0] d;
    d = now - then_t;
    return !d[TIME_W-1] && (d > {{(TIME_W-CFG_W){1'b0}}, limit});
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
  endfunction

endpackage

// File: rtl/proximity_wave_gesture_classifier.sv
// Top level of the proximity wave gesture classifier: classifier state,
// single-pass update logic and a two-deep output buffer. Uses pwgc_pkg.
//
// Usage: each input beat is one distance sample with its millisecond
// timestamp, and yields exactly one result beat (gesture none included).
// A beat is accepted at any edge where in_valid is high and in_stall low;
// one sample can be taken every cycle while in_stall stays low. The whole
// classification (window test, debounce, wave and hold counting, release
// judgement) is one short pass of compares and 32-bit subtracts between
// the input handshake and the result register. Results sit in an output
// register backed by a skid register: a sample is still accepted while one
// result waits, and in_stall rises only when both are full. Configuration
// writes through cfg_we/cfg_index/cfg_data take effect at the next edge
// and should be made while the block is idle; indexes beyond the register
// list are ignored.
module proximity_wave_gesture_classifier (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pwgc_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pwgc_pkg::out_beat_t                 out_data,
  input  logic                                cfg_we,
  input  logic [pwgc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pwgc_pkg::CFG_W-1:0]          cfg_data
);

  // configuration registers
  logic [pwgc_pkg::CFG_W-1:0] range_low_r, range_high_r, debounce_ms_r;
  logic [pwgc_pkg::CFG_W-1:0] repeat_win_r, hold_step_r, release_ms_r, step_tol_r;

  // classifier state
  logic                        inside_valid_r, inside_valid_nxt;
  logic [pwgc_pkg::TIME_W-1:0] enter_time_r, enter_time_nxt;
  logic [pwgc_pkg::TIME_W-1:0] leave_time_r, leave_time_nxt;
  logic [pwgc_pkg::TIME_W-1:0] last_hold_r, last_hold_nxt;
  logic [pwgc_pkg::CNT_W-1:0]  wave_count_r, wave_count_nxt;
  logic [pwgc_pkg::CNT_W-1:0]  hold_count_r, hold_count_nxt;
  logic [pwgc_pkg::DIST_W-1:0] enter_dist_r, enter_dist_nxt;
  logic [pwgc_pkg::DIST_W-1:0] hold_start_r, hold_start_nxt;
  logic [pwgc_pkg::DIST_W-1:0] hold_end_r, hold_end_nxt;

  // output buffer
  logic                out_valid_r, skid_valid_r;
  pwgc_pkg::out_beat_t out_data_r, skid_data_r;
  pwgc_pkg::out_beat_t res;

  logic in_acc, out_acc;

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_acc   = out_valid_r && !out_stall;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r   <= '0;
      range_high_r  <= '0;
      debounce_ms_r <= '0;
      repeat_win_r  <= '0;
      hold_step_r   <= '0;
      release_ms_r  <= pwgc_pkg::RELEASE_MS_RESET;
      step_tol_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pwgc_pkg::REG_RANGE_LOW:      range_low_r   <= cfg_data;
        pwgc_pkg::REG_RANGE_HIGH:     range_high_r  <= cfg_data;
        pwgc_pkg::REG_DEBOUNCE_MS:    debounce_ms_r <= cfg_data;
        pwgc_pkg::REG_REPEAT_WIN_MS:  repeat_win_r  <= cfg_data;
        pwgc_pkg::REG_HOLD_STEP_MS:   hold_step_r   <= cfg_data;
        pwgc_pkg::REG_RELEASE_MS:     release_ms_r  <= cfg_data;
        pwgc_pkg::REG_STEP_TOLERANCE: step_tol_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Classification of one sample
  // ---------------------------------------------------------------------
  logic [pwgc_pkg::DIST_W-1:0] samp_dist, lo, hi;
  logic [pwgc_pkg::TIME_W-1:0] now;
  logic                        outside;
  logic [pwgc_pkg::CNT_W-1:0]  wave_upd, hold_inc;
  logic signed [pwgc_pkg::DIST_W:0] travel;
  logic [pwgc_pkg::DIST_W:0]   travel_mag;

  always_comb begin
    samp_dist = in_data.distance;
    now       = in_data.time_ms;
    // window is between the smaller and larger bound, whichever register holds it
    lo = (range_low_r < range_high_r) ? range_low_r : range_high_r;
    hi = (range_low_r < range_high_r) ? range_high_r : range_low_r;
    outside = (samp_dist > hi) || (samp_dist < lo);

    inside_valid_nxt = inside_valid_r;
    enter_time_nxt   = enter_time_r;
    leave_time_nxt   = leave_time_r;
    last_hold_nxt    = last_hold_r;
    wave_count_nxt   = wave_count_r;
    hold_count_nxt   = hold_count_r;
    enter_dist_nxt   = enter_dist_r;
    hold_start_nxt   = hold_start_r;
    hold_end_nxt     = hold_end_r;

    res = '0;

    travel     = $signed({1'b0, hold_end_r}) - $signed({1'b0, hold_start_r});
    travel_mag = travel[pwgc_pkg::DIST_W] ? 17'(-travel) : 17'(travel);
    hold_inc   = pwgc_pkg::sat_inc(hold_count_r);
    wave_upd   = wave_count_r;

    if (outside) begin
      // debounced leave: extend the wave train or start a new one
      if (inside_valid_r && pwgc_pkg::elapsed_over(now, enter_time_r, debounce_ms_r)) begin
        if (pwgc_pkg::elapsed_over(now, leave_time_r, repeat_win_r))
          wave_upd = 8'd1;
        else
          wave_upd = pwgc_pkg::sat_inc(wave_count_r);
        leave_time_nxt   = now;
        inside_valid_nxt = 1'b0;
      end
      wave_count_nxt = wave_upd;
      // release: report the finished gesture, holds take priority
      if (pwgc_pkg::elapsed_over(now, enter_time_r, release_ms_r)) begin
        if (hold_count_r != '0) begin
          res.count         = hold_count_r;
          res.from_distance = hold_start_r;
          res.to_distance   = hold_end_r;
          if (travel_mag > {1'b0, step_tol_r})
            res.gesture = travel[pwgc_pkg::DIST_W] ? pwgc_pkg::G_FAR_TO_NEAR
                                                   : pwgc_pkg::G_NEAR_TO_FAR;
          else
            res.gesture = pwgc_pkg::G_HOLD;
        end else if (wave_upd != '0) begin
          res.gesture       = pwgc_pkg::G_WAVE;
          res.count         = wave_upd;
          res.from_distance = enter_dist_r;
          res.to_distance   = samp_dist;
        end
        wave_count_nxt   = '0;
        hold_count_nxt   = '0;
        inside_valid_nxt = 1'b0;
      end
    end else if (pwgc_pkg::elapsed_over(now, leave_time_r, debounce_ms_r)) begin
      if (!inside_valid_r) begin
        // debounced enter
        inside_valid_nxt = 1'b1;
        enter_time_nxt   = now;
        last_hold_nxt    = now;
        enter_dist_nxt   = samp_dist;
      end else if (pwgc_pkg::elapsed_over(now, last_hold_r, hold_step_r)) begin
        // another hold period gone: holding step
        hold_count_nxt = hold_inc;
        if (hold_count_r == '0)
          hold_start_nxt = samp_dist;
        hold_end_nxt  = samp_dist;
        last_hold_nxt = now;
        res.gesture       = pwgc_pkg::G_HOLDING;
        res.count         = hold_inc;
        res.from_distance = (hold_count_r == '0) ? samp_dist : hold_start_r;
        res.to_distance   = samp_dist;
      end
      leave_time_nxt = now;
    end

    res.event_res = (res.gesture != pwgc_pkg::G_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_valid_r <= 1'b0;
      enter_time_r   <= '0;
      leave_time_r   <= '0;
      last_hold_r    <= '0;
      wave_count_r   <= '0;
      hold_count_r   <= '0;
      enter_dist_r   <= '0;
      hold_start_r   <= '0;
      hold_end_r     <= '0;
    end else if (in_acc) begin
      inside_valid_r <= inside_valid_nxt;
      enter_time_r   <= enter_time_nxt;
      leave_time_r   <= leave_time_nxt;
      last_hold_r    <= last_hold_nxt;
      wave_count_r   <= wave_count_nxt;
      hold_count_r   <= hold_count_nxt;
      enter_dist_r   <= enter_dist_nxt;
      hold_start_r   <= hold_start_nxt;
      hold_end_r     <= hold_end_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Output register with skid stage
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_acc) begin
        // main register free this edge: skid drains first, else new beat
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_acc;
        end
      end else if (in_acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_acc) begin
      if (skid_valid_r)
        out_data_r <= skid_data_r;
      else if (in_acc)
        out_data_r <= res;
    end
    if (in_acc && out_valid_r && !out_acc)
      skid_data_r <= res;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while output register is empty");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.gesture == pwgc_pkg::G_NONE |->
      out_data_r.count == '0 && out_data_r.from_distance == '0 &&
      out_data_r.to_distance == '0 && !out_data_r.event_res)
    else $error("no-gesture result carries non-zero fields");

  a_event_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.event_res == (out_data_r.gesture != pwgc_pkg::G_NONE))
    else $error("event flag disagrees with gesture code");

  a_stalled_beat_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && in_acc |=> skid_valid_r)
    else $error("beat accepted behind stalled output was lost");

  a_hold_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.gesture == pwgc_pkg::G_HOLDING |-> out_data_r.count != '0)
    else $error("holding step with zero count");

endmodule
